@@ design/link_retry_backoff_and_signal_grade_defines.svh @@
// assertion macros used by the link retry and signal grade checker
`ifndef LINK_RETRY_BACKOFF_AND_SIGNAL_GRADE_DEFINES_SVH
`define LINK_RETRY_BACKOFF_AND_SIGNAL_GRADE_DEFINES_SVH

// same-cycle implication, muted while reset is held
`define LRBSG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, muted while reset is held
`define LRBSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/lrbsg_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and types for the link retry and signal grade block
package lrbsg_pkg;

    // samples per averaging batch and number of backoff steps in use
    localparam int BATCH_SAMPLES = 11;
    localparam int BACKOFF_STEPS = 8;

    localparam int STEP_W  = 3;
    localparam int COUNT_W = 4;
    localparam int SUM_W   = 12;
    localparam int DBM_W   = 8;
    localparam int TIME_W  = 32;

    localparam logic [STEP_W-1:0]  STEP_LAST   = STEP_W'(BACKOFF_STEPS - 1);
    localparam logic [COUNT_W-1:0] BATCH_COUNT = COUNT_W'(BATCH_SAMPLES);

    // reciprocal for the divide by batch size: exact for magnitudes below 2^12
    localparam int DIV_SHIFT   = 16;
    localparam int DIV_RECIP_W = 16;
    localparam int PROD_W      = SUM_W + DIV_RECIP_W;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP =
        DIV_RECIP_W'(((2 ** DIV_SHIFT) + BATCH_SAMPLES - 1) / BATCH_SAMPLES);

    // backoff delay in ms per retry step
    localparam logic [TIME_W-1:0] BACKOFF_MS [8] = '{
        32'd100, 32'd500, 32'd1000, 32'd5000,
        32'd10000, 32'd30000, 32'd60000, 32'd300000
    };

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRONG_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 2'd2;

    localparam logic signed [DBM_W-1:0] STRONG_THR_RESET = -8'sd60;
    localparam logic signed [DBM_W-1:0] GOOD_THR_RESET   = -8'sd70;
    localparam logic [7:0]              SETTLE_RESET     = 8'd100;

    typedef enum logic [1:0] {
        QUAL_NONE   = 2'd0,
        QUAL_BAD    = 2'd1,
        QUAL_GOOD   = 2'd2,
        QUAL_STRONG = 2'd3
    } quality_t;

endpackage

@@ design/link_retry_backoff_and_signal_grade.sv @@
`timescale 1ns / 1ps
// link retry backoff and signal grade: top level
// One poll word is taken per clock and gives exactly one result word. A poll
// accepted lands in an input register, is worked on by a single pass of
// logic (a 32-bit elapsed-time subtract and compare against the backoff
// table, the stable counter, the batch sum and one reciprocal multiply for
// the batch average) and is written to the result register when that
// register is free or draining. Throughput is one word per cycle; the
// result register lets a new poll enter while a finished result still
// waits on m_ready, and only a stall on the result side holds the input.
// While the link is down, a reconnect request is raised when the time since
// the last attempt exceeds the delay of the current retry step; while up,
// the backoff clears and, after settle_reg connected polls, samples are
// averaged in batches and graded. The user must write thresholds and settle
// count through the cfg port only while no poll is in flight; the block does
// not enforce it.
module link_retry_backoff_and_signal_grade (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // poll words
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_link_up,
    input  logic signed [lrbsg_pkg::DBM_W-1:0]    s_rssi_sample,
    input  logic [lrbsg_pkg::TIME_W-1:0]          s_time_ms,
    // result words
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_reconnect_request,
    output logic [1:0]                            m_quality,
    output logic signed [lrbsg_pkg::DBM_W-1:0]    m_average_rssi,
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [lrbsg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [7:0]                            cfg_wdata
);

    // configuration
    logic signed [lrbsg_pkg::DBM_W-1:0] strong_thr_reg;
    logic signed [lrbsg_pkg::DBM_W-1:0] good_thr_reg;
    logic [7:0]                         settle_reg;

    // input register
    logic                               in_valid_reg;
    logic                               in_link_up_reg;
    logic signed [lrbsg_pkg::DBM_W-1:0] in_rssi_reg;
    logic [lrbsg_pkg::TIME_W-1:0]       in_time_reg;

    // link state
    logic [lrbsg_pkg::TIME_W-1:0]        last_attempt_reg, last_attempt_next;
    logic [lrbsg_pkg::STEP_W-1:0]        retry_step_reg, retry_step_next;
    logic [7:0]                          stable_count_reg, stable_count_next;
    logic [lrbsg_pkg::COUNT_W-1:0]       batch_count_reg, batch_count_next;
    logic signed [lrbsg_pkg::SUM_W-1:0]  batch_sum_reg, batch_sum_next;
    logic signed [lrbsg_pkg::DBM_W-1:0]  held_average_reg, held_average_next;
    lrbsg_pkg::quality_t                 held_quality_reg, held_quality_next;

    // result register
    logic                                m_valid_reg;
    logic                                out_request_reg;
    lrbsg_pkg::quality_t                 out_quality_reg;
    logic signed [lrbsg_pkg::DBM_W-1:0]  out_average_reg;

    // datapath
    logic                                out_free;
    logic                                advance;
    logic                                in_take;
    logic                                request_next;
    logic [lrbsg_pkg::TIME_W-1:0]        elapsed;
    logic [8:0]                          stable_inc;
    logic [7:0]                          stable_sat;
    logic [lrbsg_pkg::SUM_W-1:0]         sum_mag;
    logic [lrbsg_pkg::PROD_W-1:0]        div_prod;
    logic [lrbsg_pkg::SUM_W-1:0]         quot_mag;
    logic signed [lrbsg_pkg::DBM_W-1:0]  avg;

    // handshake: result register free or draining this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign in_take  = s_valid && s_ready;

    assign m_valid             = m_valid_reg;
    assign m_reconnect_request = out_request_reg;
    assign m_quality           = out_quality_reg;
    assign m_average_rssi      = out_average_reg;

    // elapsed time wraps modulo 2^32
    assign elapsed = in_time_reg - last_attempt_reg;

    // saturating stable counter, clamped to the settle count
    assign stable_inc = {1'b0, stable_count_reg} + 9'd1;
    assign stable_sat = (stable_inc > {1'b0, settle_reg}) ? settle_reg : stable_inc[7:0];

    // batch average: divide magnitude by reciprocal multiply, truncate to zero
    assign sum_mag  = batch_sum_reg[lrbsg_pkg::SUM_W-1] ?
                      lrbsg_pkg::SUM_W'(-batch_sum_reg) : lrbsg_pkg::SUM_W'(batch_sum_reg);
    assign div_prod = lrbsg_pkg::PROD_W'(sum_mag) * lrbsg_pkg::PROD_W'(lrbsg_pkg::DIV_RECIP);
    assign quot_mag = div_prod[lrbsg_pkg::DIV_SHIFT +: lrbsg_pkg::SUM_W];
    assign avg      = batch_sum_reg[lrbsg_pkg::SUM_W-1] ?
                      lrbsg_pkg::DBM_W'(-quot_mag) : quot_mag[lrbsg_pkg::DBM_W-1:0];

    always_comb begin
        last_attempt_next = last_attempt_reg;
        retry_step_next   = retry_step_reg;
        stable_count_next = stable_count_reg;
        batch_count_next  = batch_count_reg;
        batch_sum_next    = batch_sum_reg;
        held_average_next = held_average_reg;
        held_quality_next = held_quality_reg;
        request_next      = 1'b0;

        if (in_link_up_reg) begin
            // connected: backoff clears, stable counter runs
            retry_step_next   = '0;
            stable_count_next = stable_sat;
            if (stable_sat >= settle_reg) begin
                if (batch_count_reg < lrbsg_pkg::BATCH_COUNT) begin
                    batch_sum_next   = batch_sum_reg +
                        {{(lrbsg_pkg::SUM_W-lrbsg_pkg::DBM_W){in_rssi_reg[lrbsg_pkg::DBM_W-1]}},
                         in_rssi_reg};
                    batch_count_next = batch_count_reg + 1'b1;
                end else begin
                    // batch full: this sample is dropped, average is taken
                    batch_sum_next   = '0;
                    batch_count_next = '0;
                    if (avg != '0) begin
                        held_average_next = avg;
                        // strong test first so it wins on inverted thresholds
                        if (avg >= strong_thr_reg) begin
                            held_quality_next = lrbsg_pkg::QUAL_STRONG;
                        end else if (avg >= good_thr_reg) begin
                            held_quality_next = lrbsg_pkg::QUAL_GOOD;
                        end else begin
                            held_quality_next = lrbsg_pkg::QUAL_BAD;
                        end
                    end
                end
            end
        end else if (elapsed > lrbsg_pkg::BACKOFF_MS[retry_step_reg]) begin
            // down and backoff expired: new attempt
            request_next      = 1'b1;
            last_attempt_next = in_time_reg;
            held_quality_next = lrbsg_pkg::QUAL_NONE;
            stable_count_next = '0;
            retry_step_next   = (retry_step_reg >= lrbsg_pkg::STEP_LAST) ?
                                lrbsg_pkg::STEP_LAST : retry_step_reg + 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strong_thr_reg <= lrbsg_pkg::STRONG_THR_RESET;
            good_thr_reg   <= lrbsg_pkg::GOOD_THR_RESET;
            settle_reg     <= lrbsg_pkg::SETTLE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                lrbsg_pkg::CFG_STRONG_THR: strong_thr_reg <= cfg_wdata;
                lrbsg_pkg::CFG_GOOD_THR:   good_thr_reg   <= cfg_wdata;
                lrbsg_pkg::CFG_SETTLE:     settle_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // control and link state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            last_attempt_reg <= '0;
            retry_step_reg   <= '0;
            stable_count_reg <= '0;
            batch_count_reg  <= '0;
            batch_sum_reg    <= '0;
            held_average_reg <= '0;
            held_quality_reg <= lrbsg_pkg::QUAL_NONE;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance) begin
                last_attempt_reg <= last_attempt_next;
                retry_step_reg   <= retry_step_next;
                stable_count_reg <= stable_count_next;
                batch_count_reg  <= batch_count_next;
                batch_sum_reg    <= batch_sum_next;
                held_average_reg <= held_average_next;
                held_quality_reg <= held_quality_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_link_up_reg <= s_link_up;
            in_rssi_reg    <= s_rssi_sample;
            in_time_reg    <= s_time_ms;
        end
        if (advance) begin
            out_request_reg <= request_next;
            out_quality_reg <= held_quality_next;
            out_average_reg <= held_average_next;
        end
    end

endmodule

@@ design/lrbsg_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the link retry and signal grade block
`include "link_retry_backoff_and_signal_grade_defines.svh"

module lrbsg_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_reconnect_request,
    input logic [1:0]                          m_quality,
    input logic signed [lrbsg_pkg::DBM_W-1:0]  m_average_rssi
);

    // a stalled result word holds
    `LRBSG_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_reconnect_request) && $stable(m_quality) && $stable(m_average_rssi))

    // a reconnect attempt always marks quality unavailable
    `LRBSG_ASSERT_NOW(a_req_no_grade, aclk, aresetn, m_valid && m_reconnect_request, m_quality == lrbsg_pkg::QUAL_NONE)

    // a grade is only ever given alongside a nonzero average
    `LRBSG_ASSERT_NOW(a_grade_has_avg, aclk, aresetn, m_valid && (m_quality != lrbsg_pkg::QUAL_NONE), m_average_rssi != '0)

endmodule

bind link_retry_backoff_and_signal_grade lrbsg_checker u_lrbsg_checker (.*);
